// ===== hdl/mcaru_pkg.sv =====
`timescale 1ns / 1ps
package mcaru_pkg;

  localparam int Blocks = 4096;
  localparam int BlkW = $clog2(Blocks);

  localparam logic [6:0] OpWr16    = 7'd8;
  localparam logic [6:0] OpPwr16   = 7'd24;
  localparam logic [6:0] OpRd16    = 7'd48;
  localparam logic [6:0] Op2Add8   = 7'd18;
  localparam logic [6:0] OpP2Add8  = 7'd34;
  localparam logic [6:0] OpAdd16   = 7'd19;
  localparam logic [6:0] OpPAdd16  = 7'd35;
  localparam logic [6:0] Op2Adds8r = 7'd82;
  localparam logic [6:0] OpAdds16r = 7'd83;
  localparam logic [6:0] OpInc8    = 7'd80;
  localparam logic [6:0] OpPInc8   = 7'd84;
  localparam logic [6:0] OpXor16   = 7'd64;
  localparam logic [6:0] OpOr16    = 7'd65;
  localparam logic [6:0] OpNor16   = 7'd66;
  localparam logic [6:0] OpAnd16   = 7'd67;
  localparam logic [6:0] OpNand16  = 7'd68;
  localparam logic [6:0] OpCasGt8  = 7'd96;
  localparam logic [6:0] OpCasLt8  = 7'd97;
  localparam logic [6:0] OpCasGt16 = 7'd98;
  localparam logic [6:0] OpCasLt16 = 7'd99;
  localparam logic [6:0] OpCasEq8  = 7'd100;
  localparam logic [6:0] OpCasZ16  = 7'd101;
  localparam logic [6:0] OpEq8     = 7'd105;
  localparam logic [6:0] OpEq16    = 7'd104;
  localparam logic [6:0] OpBwr     = 7'd17;
  localparam logic [6:0] OpPBwr    = 7'd33;
  localparam logic [6:0] OpBwr8r   = 7'd81;
  localparam logic [6:0] OpSwap16  = 7'd106;
  localparam logic [6:0] OpMdRd    = 7'd40;
  localparam logic [6:0] OpMdWr    = 7'd16;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StBadCmd = 2'd1;
  localparam logic [1:0] StBadAdr = 2'd2;
  localparam logic [1:0] StBadMod = 2'd3;

  localparam logic [1:0] KdRead = 2'd0;
  localparam logic [1:0] KdWrite = 2'd1;
  localparam logic [1:0] KdMode = 2'd2;

  localparam logic CfgCubeId = 1'b0;
  localparam logic CfgMaxBlk = 1'b1;

  // classified request handed from front to back
  typedef struct packed {
    logic          mem;     // needs the block store
    logic          posted;
    logic [6:0]    op;
    logic [BlkW-1:0] blk;
    logic [63:0]   d0;
    logic [63:0]   d1;
    logic [63:0]   rl;      // immediate result for non-memory items
    logic [1:0]    st;
    logic [1:0]    fl;
    logic [1:0]    kd;
  } req_t;

  typedef struct packed {
    logic [63:0] rl;
    logic [63:0] rh;
    logic        af;
    logic [1:0]  st;
    logic [1:0]  fl;
    logic [1:0]  kd;
  } rsp_t;

endpackage

// ===== hdl/memory_cube_atomic_request_unit.sv =====
`timescale 1ns / 1ps
// Block requests go through capture, block read, then execute and write back;
// mode-register and error requests go through capture and execute only.
// A new request is captured only while idle, and execute waits while the
// output register holds a response the receiver has not taken.
// A two-entry queue decouples intake from execution.
// Reset (async, active low) clears control and config; store is undefined.
module memory_cube_atomic_request_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [8:0]   cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // op[6:0], addr[40:7], wdata_low[104:41], wdata_high[168:105], zero fill
  input  logic [175:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // rdata_low[63:0], rdata_high[127:64], atomic_flag[128], status[130:129],
  // resp_flits[132:131], resp_kind[134:133], zero fill
  output logic [135:0] m_axis_tdata_o
);
  import mcaru_pkg::*;

  req_t req_f, req_b;
  rsp_t rsp;
  logic q_valid, q_ready;

  mcaru_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .op_i(s_axis_tdata_i[6:0]), .addr_i(s_axis_tdata_i[40:7]),
    .d0_i(s_axis_tdata_i[104:41]), .d1_i(s_axis_tdata_i[168:105]),
    .req_o(req_f)
  );

  mcaru_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o), .in_i(req_f),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_o(req_b)
  );

  mcaru_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i(q_valid), .req_ready_o(q_ready), .req_i(req_b),
    .rsp_valid_o(m_axis_tvalid_o), .rsp_ready_i(m_axis_tready_i), .rsp_o(rsp)
  );

  assign m_axis_tdata_o = {1'b0, rsp.kd, rsp.fl, rsp.st, rsp.af, rsp.rh, rsp.rl};

endmodule

// ===== hdl/mcaru_front.sv =====
`timescale 1ns / 1ps
module mcaru_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [8:0]          cfg_data_i,
  input  logic [6:0]          op_i,
  input  logic [33:0]         addr_i,
  input  logic [63:0]         d0_i,
  input  logic [63:0]         d1_i,
  output mcaru_pkg::req_t     req_o
);
  import mcaru_pkg::*;

  logic [2:0] cube_id_q;
  logic [8:0] max_blk_q;
  logic       blk_ok;
  logic       cls_mem;
  logic       cls_posted;
  logic [1:0] cls_fl;
  logic [1:0] cls_kd;
  logic [1:0] cls_st;
  logic [63:0] cls_rl;
  logic [21:0] mreg;

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_id_q <= 3'd0;
      max_blk_q <= 9'd128;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgCubeId) cube_id_q <= cfg_data_i[2:0];
      else                        max_blk_q <= cfg_data_i;
    end
  end

  assign blk_ok = (addr_i[33:4] < 30'(Blocks));
  assign mreg   = addr_i[21:0];

  // classify the command
  always_comb begin
    cls_mem = 1'b0;
    cls_posted = 1'b0;
    cls_fl = 2'd0;
    cls_kd = KdRead;
    cls_st = StOk;
    cls_rl = '0;
    case (op_i)
      OpPwr16, OpP2Add8, OpPAdd16, OpPInc8, OpPBwr: begin
        cls_mem = 1'b1; cls_posted = 1'b1; cls_kd = KdWrite;
      end
      OpWr16, Op2Add8, OpAdd16, OpInc8, OpEq8, OpEq16, OpBwr: begin
        cls_mem = 1'b1; cls_fl = 2'd1; cls_kd = KdWrite;
      end
      OpRd16, Op2Adds8r, OpAdds16r, OpXor16, OpOr16, OpNor16, OpAnd16, OpNand16,
      OpCasGt8, OpCasLt8, OpCasGt16, OpCasLt16, OpCasEq8, OpCasZ16, OpBwr8r,
      OpSwap16: begin
        cls_mem = 1'b1; cls_fl = 2'd2; cls_kd = KdRead;
      end
      OpMdRd: begin
        if (mreg == 22'd0) begin
          cls_rl = {61'd0, cube_id_q}; cls_fl = 2'd2; cls_kd = KdMode;
        end else if (mreg == 22'd1) begin
          cls_rl = {55'd0, max_blk_q}; cls_fl = 2'd2; cls_kd = KdMode;
        end else begin
          cls_st = StBadMod;
        end
      end
      OpMdWr:  cls_st = StBadMod;
      default: cls_st = StBadCmd;
    endcase
    // out-of-range block turns a memory request into an error
    if (cls_mem && !blk_ok) begin
      cls_mem = 1'b0; cls_posted = 1'b0; cls_st = StBadAdr;
      cls_fl = 2'd0; cls_kd = KdRead;
    end
  end

  always_comb begin
    req_o.mem    = cls_mem;
    req_o.posted = cls_posted;
    req_o.op     = op_i;
    req_o.blk    = addr_i[BlkW+3:4];
    req_o.d0     = d0_i;
    req_o.d1     = d1_i;
    req_o.rl     = cls_rl;
    req_o.st     = cls_st;
    req_o.fl     = cls_fl;
    req_o.kd     = cls_kd;
  end

endmodule

// ===== hdl/mcaru_back.sv =====
`timescale 1ns / 1ps
module mcaru_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  mcaru_pkg::req_t  req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output mcaru_pkg::rsp_t  rsp_o
);
  import mcaru_pkg::*;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SRead = 2'd1;
  localparam logic [1:0] SExec = 2'd2;

  logic [1:0]  state_q, state_d;
  req_t        cur_q;
  logic [63:0] mem_lo [Blocks];
  logic [63:0] mem_hi [Blocks];
  logic [63:0] ml_q, mh_q;
  logic [63:0] nl, nh, rl, rh;
  logic        af;
  logic        carry;
  logic [63:0] sum_lo;
  logic        out_v_q;
  rsp_t        out_q;
  logic        out_free;
  logic        wr_en;
  logic [63:0] bw_lo, bw_hi;

  assign out_free    = !out_v_q || rsp_ready_i;
  assign req_ready_o = (state_q == SIdle);
  assign rsp_valid_o = out_v_q;
  assign rsp_o       = out_q;

  // sequence: capture, read block for memory requests, execute and write back
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (req_valid_i) state_d = req_i.mem ? SRead : SExec;
      SRead: state_d = SExec;
      SExec: if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && req_valid_i) cur_q <= req_i;
  end

  // block store with registered read
  always_ff @(posedge clk_i) begin
    if (state_q == SRead) begin
      ml_q <= mem_lo[cur_q.blk];
      mh_q <= mem_hi[cur_q.blk];
    end
    if (wr_en) begin
      mem_lo[cur_q.blk] <= nl;
      mem_hi[cur_q.blk] <= nh;
    end
  end

  assign {carry, sum_lo} = {1'b0, ml_q} + {1'b0, cur_q.d0};

  always_comb begin
    case (cur_q.op)
      OpXor16:  begin bw_lo = ml_q ^ cur_q.d0;    bw_hi = mh_q ^ cur_q.d1;    end
      OpOr16:   begin bw_lo = ml_q | cur_q.d0;    bw_hi = mh_q | cur_q.d1;    end
      OpNor16:  begin bw_lo = ~(ml_q | cur_q.d0); bw_hi = ~(mh_q | cur_q.d1); end
      OpAnd16:  begin bw_lo = ml_q & cur_q.d0;    bw_hi = mh_q & cur_q.d1;    end
      default:  begin bw_lo = ~(ml_q & cur_q.d0); bw_hi = ~(mh_q & cur_q.d1); end
    endcase
  end

  // compute new block contents and returned data
  always_comb begin
    nl = ml_q; nh = mh_q; rl = '0; rh = '0; af = 1'b0;
    case (cur_q.op)
      OpWr16, OpPwr16: begin nl = cur_q.d0; nh = cur_q.d1; end
      OpRd16: begin rl = ml_q; rh = mh_q; end
      Op2Add8, OpP2Add8: begin
        nl = ml_q + {32'd0, cur_q.d0[31:0]};
        nh = mh_q + {32'd0, cur_q.d1[31:0]};
      end
      Op2Adds8r: begin
        nl = ml_q + cur_q.d0; nh = mh_q + cur_q.d1; rl = ml_q; rh = mh_q;
      end
      OpAdd16, OpPAdd16: begin
        nl = sum_lo; nh = mh_q + cur_q.d1 + {63'd0, carry};
      end
      OpAdds16r: begin
        nl = sum_lo; nh = mh_q + cur_q.d1 + {63'd0, carry}; rl = ml_q; rh = mh_q;
      end
      OpInc8, OpPInc8: nl = ml_q + 64'd1;
      OpXor16, OpOr16, OpNor16, OpAnd16, OpNand16: begin
        nl = bw_lo; nh = bw_hi; rl = ml_q; rh = mh_q;
        af = (bw_lo != ml_q) || (bw_hi != mh_q);
      end
      OpCasGt8: begin
        rl = ml_q;
        if (cur_q.d0 > ml_q) begin nl = cur_q.d0; af = 1'b1; end
      end
      OpCasLt8: begin
        rl = ml_q;
        if (cur_q.d0 < ml_q) begin nl = cur_q.d0; af = 1'b1; end
      end
      OpCasGt16: begin
        rl = ml_q; rh = mh_q;
        if ({cur_q.d1, cur_q.d0} > {mh_q, ml_q}) begin
          nl = cur_q.d0; nh = cur_q.d1; af = 1'b1;
        end
      end
      OpCasLt16: begin
        rl = ml_q; rh = mh_q;
        if ({mh_q, ml_q} > {cur_q.d1, cur_q.d0}) begin
          nl = cur_q.d0; nh = cur_q.d1; af = 1'b1;
        end
      end
      OpCasEq8: begin
        rl = ml_q;
        if (cur_q.d0 == ml_q) begin nl = cur_q.d1; af = 1'b1; end
      end
      OpCasZ16: begin
        rl = ml_q; rh = mh_q;
        if (ml_q == '0 && mh_q == '0) begin
          nl = cur_q.d0; nh = cur_q.d1; af = 1'b1;
        end
      end
      OpEq8:  af = (cur_q.d0 == ml_q);
      OpEq16: af = (cur_q.d0 == ml_q) && (cur_q.d1 == mh_q);
      OpBwr, OpPBwr: nl = (ml_q & ~cur_q.d1) | (cur_q.d0 & cur_q.d1);
      OpBwr8r: begin
        nl = (ml_q & ~cur_q.d1) | (cur_q.d0 & cur_q.d1); rl = ml_q;
      end
      OpSwap16: begin nl = cur_q.d0; nh = cur_q.d1; rl = ml_q; rh = mh_q; end
      default: ;
    endcase
  end

  assign wr_en = (state_q == SExec) && out_free && cur_q.mem;

  // drive the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (state_q == SExec && out_free) begin
      out_v_q <= !(cur_q.mem && cur_q.posted);
    end else if (rsp_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SExec && out_free) begin
      out_q.st <= cur_q.st;
      out_q.fl <= cur_q.fl;
      out_q.kd <= cur_q.kd;
      if (cur_q.mem) begin
        out_q.rl <= rl; out_q.rh <= rh; out_q.af <= af;
      end else begin
        out_q.rl <= cur_q.rl; out_q.rh <= '0; out_q.af <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/mcaru_fifo.sv =====
`timescale 1ns / 1ps
module mcaru_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mcaru_pkg::req_t  in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mcaru_pkg::req_t  out_o
);
  import mcaru_pkg::*;

  req_t       slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = slot_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wp_q] <= in_i;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import mcaru_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [63:0] rl;
    logic [63:0] rh;
    logic        af;
    logic [1:0]  st;
    logic [1:0]  fl;
    logic [1:0]  kd;
  } result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic         cfg_idx_i = 1'b0;
  logic [8:0]   cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [175:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [135:0] m_axis_tdata_o;

  memory_cube_atomic_request_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow copy of the block store and mode registers
  logic [63:0] shadow_lo [Blocks];
  logic [63:0] shadow_hi [Blocks];
  bit          written [Blocks];
  logic [2:0]  cube_id_q = '0;
  logic [8:0]  max_blk_q = 9'd128;

  result_t pending_q[$];
  int      errors = 0;
  int      cycles = 0;
  int      n_sent = 0;
  int      n_got = 0;
  bit      hold_rx = 0;
  int      hold_cycles = 0;
  bit      quiet = 0;

  // compute the response a request causes and update the shadow store
  function automatic void predict_request(logic [6:0] op, logic [33:0] addr,
                                          logic [63:0] d0, logic [63:0] d1);
    result_t r;
    logic [63:0] ml, mh, nl, nh;
    logic [33:0] blk;
    bit posted;
    r = '0;
    posted = 0;
    case (op)
      OpPwr16, OpP2Add8, OpPAdd16, OpPInc8, OpPBwr: begin
        posted = 1; r.kd = KdWrite;
      end
      OpWr16, Op2Add8, OpAdd16, OpInc8, OpEq8, OpEq16, OpBwr: begin
        r.fl = 2'd1; r.kd = KdWrite;
      end
      OpRd16, Op2Adds8r, OpAdds16r, OpXor16, OpOr16, OpNor16, OpAnd16, OpNand16,
      OpCasGt8, OpCasLt8, OpCasGt16, OpCasLt16, OpCasEq8, OpCasZ16, OpBwr8r,
      OpSwap16: begin
        r.fl = 2'd2; r.kd = KdRead;
      end
      OpMdRd: begin
        if (addr[21:0] == 22'd0) begin
          r.rl = {61'd0, cube_id_q}; r.fl = 2'd2; r.kd = KdMode;
        end else if (addr[21:0] == 22'd1) begin
          r.rl = {55'd0, max_blk_q}; r.fl = 2'd2; r.kd = KdMode;
        end else r.st = StBadMod;
        pending_q.push_back(r);
        return;
      end
      OpMdWr: begin
        r.st = StBadMod; pending_q.push_back(r); return;
      end
      default: begin
        r.st = StBadCmd; pending_q.push_back(r); return;
      end
    endcase
    blk = addr >> 4;
    if (blk >= Blocks) begin
      r = '0; r.st = StBadAdr; pending_q.push_back(r); return;
    end
    ml = shadow_lo[blk[BlkW-1:0]]; mh = shadow_hi[blk[BlkW-1:0]];
    nl = ml; nh = mh;
    case (op)
      OpWr16, OpPwr16: begin nl = d0; nh = d1; end
      OpRd16: begin r.rl = ml; r.rh = mh; end
      Op2Add8, OpP2Add8: begin
        nl = ml + {32'd0, d0[31:0]}; nh = mh + {32'd0, d1[31:0]};
      end
      Op2Adds8r: begin nl = ml + d0; nh = mh + d1; r.rl = ml; r.rh = mh; end
      OpAdd16, OpPAdd16, OpAdds16r: begin
        {nh, nl} = {mh, ml} + {d1, d0};
        if (op == OpAdds16r) begin r.rl = ml; r.rh = mh; end
      end
      OpInc8, OpPInc8: nl = ml + 64'd1;
      OpXor16, OpOr16, OpNor16, OpAnd16, OpNand16: begin
        case (op)
          OpXor16: begin nl = ml ^ d0; nh = mh ^ d1; end
          OpOr16:  begin nl = ml | d0; nh = mh | d1; end
          OpNor16: begin nl = ~(ml | d0); nh = ~(mh | d1); end
          OpAnd16: begin nl = ml & d0; nh = mh & d1; end
          default: begin nl = ~(ml & d0); nh = ~(mh & d1); end
        endcase
        r.af = (nl != ml) || (nh != mh);
        r.rl = ml; r.rh = mh;
      end
      OpCasGt8: begin if (d0 > ml) begin nl = d0; r.af = 1; end r.rl = ml; end
      OpCasLt8: begin if (d0 < ml) begin nl = d0; r.af = 1; end r.rl = ml; end
      OpCasGt16: begin
        if ({d1, d0} > {mh, ml}) begin nl = d0; nh = d1; r.af = 1; end
        r.rl = ml; r.rh = mh;
      end
      OpCasLt16: begin
        if ({mh, ml} > {d1, d0}) begin nl = d0; nh = d1; r.af = 1; end
        r.rl = ml; r.rh = mh;
      end
      OpCasEq8: begin if (d0 == ml) begin nl = d1; r.af = 1; end r.rl = ml; end
      OpCasZ16: begin
        if (ml == 0 && mh == 0) begin nl = d0; nh = d1; r.af = 1; end
        r.rl = ml; r.rh = mh;
      end
      OpEq8: r.af = (d0 == ml);
      OpEq16: r.af = (d0 == ml) && (d1 == mh);
      OpBwr, OpPBwr, OpBwr8r: begin
        nl = (ml & ~d1) | (d0 & d1);
        if (op == OpBwr8r) r.rl = ml;
      end
      default: begin nl = d0; nh = d1; r.rl = ml; r.rh = mh; end
    endcase
    shadow_lo[blk[BlkW-1:0]] = nl; shadow_hi[blk[BlkW-1:0]] = nh;
    if (!posted) pending_q.push_back(r);
  endfunction

  // false only for the full writes (OpWr16, OpPwr16); true for every other op
  function automatic bit reads_block(logic [6:0] op);
    return !(op == OpWr16 || op == OpPwr16);
  endfunction

  // drive one request beat and wait for acceptance
  task automatic send_request(logic [6:0] op, logic [33:0] addr,
                              logic [63:0] d0, logic [63:0] d1);
    logic [33:0] blk;
    blk = addr >> 4;
    // keep never-written blocks out of reach of reading ops
    if (blk < Blocks && reads_block(op) && !written[blk[BlkW-1:0]] &&
        op != OpMdRd && op != OpMdWr) begin
      op = OpWr16;
    end
    while (!quiet && $urandom_range(99) < 6) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, d1, d0, addr, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_request(op, addr, d0, d1);
    if (blk < Blocks && (op == OpWr16 || op == OpPwr16)) written[blk[BlkW-1:0]] = 1;
    n_sent++;
    @(negedge clk_i);
  endtask

  // drop valid, wait for every expected response, then let the pipe drain
  task automatic drain_pipe();
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    drain_pipe();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgCubeId) cube_id_q = val[2:0];
    else max_blk_q = val;
  endtask

  // mostly small live blocks so accesses collide
  function automatic logic [33:0] pick_addr();
    int k;
    k = $urandom_range(99);
    if (k < 80) return {26'd0, 4'($urandom_range(15)), 4'($urandom)};
    if (k < 90) return 34'({$urandom, $urandom} & 64'h3FFFFFFFF);
    if (k < 95) return 34'(Blocks * 16) - 34'($urandom_range(15)) - 34'd1;
    return 34'(Blocks * 16) + 34'($urandom_range(4095));
  endfunction

  function automatic logic [6:0] pick_op();
    logic [6:0] ops [30] = '{OpWr16, OpPwr16, OpRd16, Op2Add8, OpP2Add8, OpAdd16,
      OpPAdd16, Op2Adds8r, OpAdds16r, OpInc8, OpPInc8, OpXor16, OpOr16, OpNor16,
      OpAnd16, OpNand16, OpCasGt8, OpCasLt8, OpCasGt16, OpCasLt16, OpCasEq8,
      OpCasZ16, OpEq8, OpEq16, OpBwr, OpPBwr, OpBwr8r, OpSwap16, OpMdRd, OpMdWr};
    if ($urandom_range(99) < 5) return 7'($urandom);
    return ops[$urandom_range(29)];
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom} & 64'hF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    send_request(OpWr16, 34'h0, '1, '1);
    send_request(OpAdd16, 34'h0, 64'd1, 64'd0);
    send_request(OpRd16, 34'h0, '0, '0);
    send_request(OpCasZ16, 34'h0, 64'd5, 64'd6);
    send_request(OpCasEq8, 34'h0, 64'd5, 64'hABCD);
    send_request(OpCasEq8, 34'h0, 64'd5, 64'd1);
    send_request(OpWr16, 34'h3FFF3, '1, 64'h8000000000000000);
    send_request(OpCasGt16, 34'hFFF0, '0, '1);
    send_request(OpCasLt16, 34'hFFF0, '0, '0);
    send_request(OpBwr8r, 34'h1, 64'h00FF, 64'h0F0F);
    send_request(OpSwap16, 34'h2, 64'h1234, '1);
    send_request(OpEq16, 34'h0, 64'h1234, '1);
    send_request(OpNand16, 34'h0, '1, '1);
    send_request(OpPInc8, 34'h0, '0, '0);
    send_request(OpRd16, 34'h10000, '0, '0);
    send_request(OpPwr16, 34'h3FFFFFFFF, '0, '0);
    send_request(OpMdRd, 34'h0, '0, '0);
    send_request(OpMdRd, 34'h3FFC00001, '0, '0);
    send_request(OpMdRd, 34'h2, '0, '0);
    send_request(OpMdWr, 34'h0, '0, '0);
    send_request(7'd127, 34'h0, '0, '0);
    send_request(7'd0, 34'h0, '0, '0);
  endtask

  task automatic test_random(int count);
    repeat (count) send_request(pick_op(), pick_addr(), pick_word(), pick_word());
  endtask

  // fill the pipe while the receiver stalls
  task automatic test_backpressure();
    hold_cycles = 300;
    hold_rx = 1;
    quiet = 1;
    test_random(40);
    quiet = 0;
    drain_pipe();
  endtask

  // receiver readiness and response check
  always @(negedge clk_i) begin
    if (hold_rx) begin
      m_axis_tready_i <= 1'b0;
      if (--hold_cycles <= 0) hold_rx = 0;
    end else m_axis_tready_i <= quiet || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    result_t got, want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.rl = m_axis_tdata_o[63:0];
      got.rh = m_axis_tdata_o[127:64];
      got.af = m_axis_tdata_o[128];
      got.st = m_axis_tdata_o[130:129];
      got.fl = m_axis_tdata_o[132:131];
      got.kd = m_axis_tdata_o[134:133];
      n_got++;
      if (pending_q.size() == 0) begin
        $error("response with nothing pending: %h", got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.rl !== want.rl) begin
          $error("rdata_low exp %h got %h", want.rl, got.rl); errors++;
        end
        if (got.rh !== want.rh) begin
          $error("rdata_high exp %h got %h", want.rh, got.rh); errors++;
        end
        if (got.af !== want.af) begin
          $error("atomic_flag exp %b got %b", want.af, got.af); errors++;
        end
        if (got.st !== want.st) begin
          $error("status exp %0d got %0d", want.st, got.st); errors++;
        end
        if (got.fl !== want.fl) begin
          $error("resp_flits exp %0d got %0d", want.fl, got.fl); errors++;
        end
        if (got.kd !== want.kd) begin
          $error("resp_kind exp %0d got %0d", want.kd, got.kd); errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    write_reg(CfgCubeId, 9'd7);
    write_reg(CfgMaxBlk, 9'd256);
    send_request(OpMdRd, 34'h0, '0, '0);
    send_request(OpMdRd, 34'h1, '0, '0);
    test_random(500);
    test_backpressure();
    write_reg(CfgCubeId, 9'd0);
    write_reg(CfgMaxBlk, 9'd0);
    send_request(OpMdRd, 34'h1, '0, '0);
    quiet = 1;
    test_random(300);
    quiet = 0;
    write_reg(CfgCubeId, 9'($urandom_range(7)));
    write_reg(CfgMaxBlk, 9'($urandom_range(256)));
    test_random(700);
    drain_pipe();
    if (pending_q.size() != 0) errors++;
    $display("Sent %0d requests across all ops, errors and mode reads; %0d responses.",
             n_sent, n_got);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
